// ===== design/tdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpg_pkg
// Shared types and constants of the triggered delayed pulse generator.
// ----------------------------------------------------------------------------
package tdpg_pkg;

  localparam int unsigned DELAY_LIMIT_US      = 200000;
  localparam int unsigned ZERO_DELAY_EXTRA_US = 5;

  localparam int unsigned US_PER_DELAY_UNIT  = 100;
  localparam int unsigned US_PER_LENGTH_UNIT = 10;
  localparam int unsigned LENGTH_MIN_UNITS   = 1800;
  localparam int unsigned LENGTH_MAX_UNITS   = 2200;

  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COUNT_W     = 18;
  localparam int unsigned TOTAL_W     = 16;
  localparam int unsigned DLY_FB_W    = 11;
  localparam int unsigned LEN_FB_W    = 12;

  localparam int unsigned DELAY_UNITS_MAX = (DELAY_LIMIT_US + US_PER_DELAY_UNIT / 2) /
                                            US_PER_DELAY_UNIT;
  localparam int unsigned DELAY_RAW_MAX   = DELAY_LIMIT_US / US_PER_DELAY_UNIT;
  localparam int unsigned DELAY_UNITS_W   = $clog2(DELAY_UNITS_MAX + 1);
  localparam int unsigned DELAY_TICKS_W   = $clog2(DELAY_UNITS_MAX * US_PER_DELAY_UNIT + 1);
  localparam int unsigned HIGH_TICKS_W    =
    $clog2(LENGTH_MAX_UNITS * US_PER_LENGTH_UNIT + ZERO_DELAY_EXTRA_US + 1);
  localparam int unsigned CMP_W0 = (DELAY_TICKS_W > HIGH_TICKS_W) ? DELAY_TICKS_W : HIGH_TICKS_W;
  localparam int unsigned CMP_W  = (CMP_W0 > COUNT_W) ? CMP_W0 : COUNT_W;

  localparam logic [CFG_W-1:0] DELAY_RESET  = CFG_W'(0);
  localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY   = 2'd0,
    CFG_LENGTH  = 2'd1,
    CFG_TRIGGER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic sensor_level;
  } in_item_t;

  typedef struct packed {
    logic                pulse_out;
    logic                pulse_active;
    logic [TOTAL_W-1:0]  pulse_total;
    logic [DLY_FB_W-1:0] delay_feedback;
    logic [LEN_FB_W-1:0] length_feedback;
  } out_item_t;

endpackage

// ===== design/tdpg_if.sv =====
// ----------------------------------------------------------------------------
// tdpg_if
// Valid/ready channels of the triggered delayed pulse generator.
// ----------------------------------------------------------------------------
interface tdpg_in_if;
  logic              valid;
  logic              ready;
  tdpg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tdpg_out_if;
  logic               valid;
  logic               ready;
  tdpg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tdpg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tdpg_pkg::CFG_IDX_W-1:0] index;
  logic [tdpg_pkg::CFG_W-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== design/triggered_delayed_pulse_generator.sv =====
// ----------------------------------------------------------------------------
// triggered_delayed_pulse_generator
// Edge-triggered one-shot with programmable delay and pulse length.
//
// in_i carries one transaction per microsecond tick with the sampled sensor
// level; out_o returns exactly one transaction per tick with the pin level,
// busy flag, completed pulse count and the clamped settings in effect.
// cfg_i writes the delay (index 0), length (index 1) and trigger edge
// (index 2); it is always ready; the user must write it only while the block
// is idle (not enforced). One tick is taken per cycle while in_i is ready.
// The tick's whole state update sits between the state registers and the
// result register. A two-entry output stage (result plus skid) keeps input
// accepted for one more tick while the receiver stalls; in_i.ready drops
// only once both entries hold results. Reset clears the settings to their
// defaults, the edge detector, the phase, the tick counter and the pulse
// count, and empties the output stage.
// ----------------------------------------------------------------------------
module triggered_delayed_pulse_generator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tdpg_in_if.sink               in_i,
  tdpg_out_if.source            out_o,
  tdpg_cfg_if.sink              cfg_i
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_HIGH  = 2'd2
  } phase_e;

  logic [tdpg_pkg::CFG_W-1:0]    delay_cfg_q;
  logic [tdpg_pkg::CFG_W-1:0]    length_cfg_q;
  logic                          falling_q;

  logic                          last_level_q;
  phase_e                        phase_q, phase_d;
  logic [tdpg_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic [tdpg_pkg::TOTAL_W-1:0]  total_q, total_d;

  logic                          out_v_q, skid_v_q;
  tdpg_pkg::out_item_t           out_q, skid_q;
  tdpg_pkg::out_item_t           res_d;

  logic [tdpg_pkg::DELAY_UNITS_W-1:0] dly_units;
  logic [tdpg_pkg::LEN_FB_W-1:0]      len_units;
  logic [tdpg_pkg::CMP_W-1:0]         dly_ticks;
  logic [tdpg_pkg::CMP_W-1:0]         high_ticks;
  logic [tdpg_pkg::COUNT_W-1:0]       cnt_inc;
  logic                               level;
  logic                               trig;
  logic                               pin;
  logic                               active;
  logic                               acc;
  logic                               pop;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !skid_v_q;
  assign acc         = in_i.valid && in_i.ready;
  assign pop         = out_v_q && out_o.ready;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_comb begin
    if (delay_cfg_q > tdpg_pkg::CFG_W'(tdpg_pkg::DELAY_RAW_MAX)) begin
      dly_units = tdpg_pkg::DELAY_UNITS_W'(tdpg_pkg::DELAY_UNITS_MAX);
    end else begin
      dly_units = tdpg_pkg::DELAY_UNITS_W'(delay_cfg_q);
    end
    if (length_cfg_q < tdpg_pkg::CFG_W'(tdpg_pkg::LENGTH_MIN_UNITS)) begin
      len_units = tdpg_pkg::LEN_FB_W'(tdpg_pkg::LENGTH_MIN_UNITS);
    end else if (length_cfg_q > tdpg_pkg::CFG_W'(tdpg_pkg::LENGTH_MAX_UNITS)) begin
      len_units = tdpg_pkg::LEN_FB_W'(tdpg_pkg::LENGTH_MAX_UNITS);
    end else begin
      len_units = tdpg_pkg::LEN_FB_W'(length_cfg_q);
    end
    dly_ticks  = tdpg_pkg::CMP_W'(dly_units) *
                 tdpg_pkg::CMP_W'(tdpg_pkg::US_PER_DELAY_UNIT);
    high_ticks = tdpg_pkg::CMP_W'(len_units) *
                 tdpg_pkg::CMP_W'(tdpg_pkg::US_PER_LENGTH_UNIT);
    if (dly_units == '0) begin
      high_ticks = high_ticks + tdpg_pkg::CMP_W'(tdpg_pkg::ZERO_DELAY_EXTRA_US);
    end
  end

  always_comb begin
    level   = in_i.data.sensor_level;
    trig    = falling_q ? (last_level_q && !level) : (!last_level_q && level);
    phase_d = phase_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    pin     = 1'b0;
    active  = 1'b0;

    unique case (phase_q)
      PH_DELAY, PH_HIGH: begin
      end
      default: begin
        phase_d = PH_IDLE;
        if (trig) begin
          cnt_d   = '0;
          phase_d = (dly_units == '0) ? PH_HIGH : PH_DELAY;
        end
      end
    endcase

    cnt_inc = cnt_d + tdpg_pkg::COUNT_W'(1);

    unique case (phase_d)
      PH_DELAY: begin
        active = 1'b1;
        cnt_d  = cnt_inc;
        if (tdpg_pkg::CMP_W'(cnt_inc) >= dly_ticks) begin
          phase_d = PH_HIGH;
          cnt_d   = '0;
        end
      end
      PH_HIGH: begin
        active = 1'b1;
        pin    = 1'b1;
        cnt_d  = cnt_inc;
        if (tdpg_pkg::CMP_W'(cnt_inc) >= high_ticks) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
          if (total_q != '1) begin
            total_d = total_q + tdpg_pkg::TOTAL_W'(1);
          end
        end
      end
      default: begin
      end
    endcase

    res_d.pulse_out       = pin;
    res_d.pulse_active    = active;
    res_d.pulse_total     = total_d;
    res_d.delay_feedback  = tdpg_pkg::DLY_FB_W'(dly_units);
    res_d.length_feedback = len_units;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_cfg_q  <= tdpg_pkg::DELAY_RESET;
      length_cfg_q <= tdpg_pkg::LENGTH_RESET;
      falling_q    <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tdpg_pkg::CFG_DELAY:   delay_cfg_q  <= cfg_i.wdata;
        tdpg_pkg::CFG_LENGTH:  length_cfg_q <= cfg_i.wdata;
        tdpg_pkg::CFG_TRIGGER: falling_q    <= cfg_i.wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      phase_q      <= PH_IDLE;
      cnt_q        <= '0;
      total_q      <= '0;
    end else if (acc) begin
      last_level_q <= level;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= acc;
      end
    end else if (acc) begin
      if (out_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res_d;
      end
    end else if (acc) begin
      if (out_v_q) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without an output entry");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (cnt_q == '0))
    else $error("tick counter not cleared while idle");

  a_pin_implies_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.pulse_out) |-> out_q.pulse_active)
    else $error("pulse pin high outside an active pulse");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (total_q >= $past(total_q)))
    else $error("pulse count decreased");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the triggered delayed pulse generator.
//
// Streams one-microsecond sensor ticks into the block and compares every
// returned tick (pin level, busy flag, pulse count, clamped settings) against
// a cycle-free behavioral tracker of the one-shot. Idle ticks cover the clamp
// limits of both settings; one falling-edge trigger then runs through its
// delay, has the delay cut below the running count and its settings changed
// while high, with noisy sensor levels throughout.
// ----------------------------------------------------------------------------
module tb;
  import tdpg_pkg::*;

  localparam int unsigned CLK_PERIOD = 10;
  localparam longint unsigned TIMEOUT_NS = 64'd200_000;

  typedef enum logic [1:0] {
    STAGE_IDLE  = 2'd0,
    STAGE_DELAY = 2'd1,
    STAGE_HIGH  = 2'd2
  } stage_e;

  class pulse_tracker;
    logic [CFG_W-1:0]   delay_set;
    logic [CFG_W-1:0]   length_set;
    logic               falling_set;
    logic               prev_level;
    stage_e             stage;
    logic [COUNT_W-1:0] ticks;
    logic [TOTAL_W-1:0] pulses;
    out_item_t          owed[$];
    int unsigned        mismatches;
    int unsigned        results_checked;

    function new();
      delay_set       = DELAY_RESET;
      length_set      = LENGTH_RESET;
      falling_set     = 1'b0;
      prev_level      = 1'b0;
      stage           = STAGE_IDLE;
      ticks           = '0;
      pulses          = '0;
      mismatches      = 0;
      results_checked = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_DELAY:   delay_set = value;
        CFG_LENGTH:  length_set = value;
        CFG_TRIGGER: falling_set = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned delay_units();
      int unsigned us;
      us = 32'(delay_set) * US_PER_DELAY_UNIT;
      if (us > DELAY_LIMIT_US) us = DELAY_LIMIT_US;
      return (us + US_PER_DELAY_UNIT / 2) / US_PER_DELAY_UNIT;
    endfunction

    function int unsigned length_units();
      int unsigned v;
      v = 32'(length_set);
      if (v < LENGTH_MIN_UNITS) v = LENGTH_MIN_UNITS;
      else if (v > LENGTH_MAX_UNITS) v = LENGTH_MAX_UNITS;
      return v;
    endfunction

    // advance one tick and queue the pin report it owes
    function void take_tick(logic level);
      int unsigned du;
      int unsigned lu;
      int unsigned dly_ticks;
      int unsigned high_ticks;
      logic        hit;
      out_item_t   r;
      du         = delay_units();
      lu         = length_units();
      dly_ticks  = du * US_PER_DELAY_UNIT;
      high_ticks = lu * US_PER_LENGTH_UNIT;
      if (du == 0) high_ticks += ZERO_DELAY_EXTRA_US;
      hit = falling_set ? (prev_level && !level) : (!prev_level && level);
      prev_level = level;
      r = '0;
      if (stage == STAGE_IDLE && hit) begin
        ticks = '0;
        stage = (du == 0) ? STAGE_HIGH : STAGE_DELAY;
      end
      if (stage == STAGE_DELAY) begin
        r.pulse_active = 1'b1;
        ticks = ticks + COUNT_W'(1);
        if (32'(ticks) >= dly_ticks) begin
          stage = STAGE_HIGH;
          ticks = '0;
        end
      end else if (stage == STAGE_HIGH) begin
        r.pulse_active = 1'b1;
        r.pulse_out    = 1'b1;
        ticks = ticks + COUNT_W'(1);
        if (32'(ticks) >= high_ticks) begin
          stage = STAGE_IDLE;
          ticks = '0;
          if (pulses != '1) pulses = pulses + TOTAL_W'(1);
        end
      end
      r.pulse_total     = pulses;
      r.delay_feedback  = du[DLY_FB_W-1:0];
      r.length_feedback = lu[LEN_FB_W-1:0];
      owed.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        $error("pin report with no tick awaiting one");
        mismatches++;
        return;
      end
      want = owed.pop_front();
      results_checked++;
      if (got.pulse_out !== want.pulse_out) begin
        $error("pulse_out expected %0d actual %0d", want.pulse_out, got.pulse_out);
        mismatches++;
      end
      if (got.pulse_active !== want.pulse_active) begin
        $error("pulse_active expected %0d actual %0d", want.pulse_active, got.pulse_active);
        mismatches++;
      end
      if (got.pulse_total !== want.pulse_total) begin
        $error("pulse_total expected %0d actual %0d", want.pulse_total, got.pulse_total);
        mismatches++;
      end
      if (got.delay_feedback !== want.delay_feedback) begin
        $error("delay_feedback expected %0d actual %0d", want.delay_feedback,
               got.delay_feedback);
        mismatches++;
      end
      if (got.length_feedback !== want.length_feedback) begin
        $error("length_feedback expected %0d actual %0d", want.length_feedback,
               got.length_feedback);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;
  int unsigned ticks_sent = 0;
  int unsigned writes_done = 0;
  pulse_tracker tracker = new();

  tdpg_in_if  in_ch();
  tdpg_out_if out_ch();
  tdpg_cfg_if cfg_ch();

  triggered_delayed_pulse_generator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic send_tick(input logic level);
    int unsigned gap;
    if (!calm && $urandom_range(0, 31) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.sensor_level <= level;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    tracker.take_tick(level);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= value;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    tracker.set_reg(idx, value);
    writes_done++;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic flat_ticks(input int unsigned n);
    repeat (n) send_tick(tracker.prev_level);
  endtask

  task automatic noisy_ticks(input int unsigned n);
    repeat (n) send_tick(1'($urandom_range(0, 1)));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      tracker.check_result(out_ch.data);
    end
  end

  initial begin
    int unsigned hold_cycles;
    hold_cycles = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles == 0 && !calm) begin
        if (!long_hold_done && tracker.results_checked >= 200) begin
          hold_cycles = 150;
          long_hold_done = 1'b1;
        end else if ($urandom_range(0, 31) == 0) begin
          hold_cycles = $urandom_range(1, 14);
        end
      end
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("triggered_delayed_pulse_generator test failed");
    $finish;
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_DELAY;
    cfg_ch.wdata <= '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle with reset settings, then walk the clamp limits
    flat_ticks(3);
    write_reg(CFG_DELAY, 16'd2000);
    flat_ticks(2);
    write_reg(CFG_DELAY, 16'd2001);
    flat_ticks(2);
    write_reg(CFG_LENGTH, 16'd1799);
    flat_ticks(2);
    write_reg(CFG_LENGTH, 16'd1800);
    flat_ticks(2);
    write_reg(CFG_LENGTH, 16'd2200);
    flat_ticks(2);
    write_reg(CFG_LENGTH, 16'd2201);
    flat_ticks(2);
    write_reg(CFG_LENGTH, 16'hFFFF);
    flat_ticks(2);

    // falling edge selected: the rising level must not arm
    write_reg(CFG_TRIGGER, 16'd1);
    write_reg(CFG_DELAY, 16'd2);
    write_reg(CFG_LENGTH, 16'd0);
    send_tick(1'b1);
    flat_ticks(4);
    send_tick(1'b0);
    noisy_ticks(120);

    // cut the delay below the running count, then change settings while high
    write_reg(CFG_DELAY, 16'd1);
    noisy_ticks(100);
    write_reg(CFG_DELAY, 16'd0);
    write_reg(CFG_LENGTH, 16'd2201);
    noisy_ticks(100);
    calm = 1'b1;
    write_reg(CFG_TRIGGER, 16'd0);
    noisy_ticks(80);

    in_ch.valid <= 1'b0;
    while (tracker.owed.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("%0d sensor ticks sent, %0d register writes, %0d pulses completed",
             ticks_sent, writes_done, tracker.pulses);
    $display("%0d pin reports checked, %0d mismatches", tracker.results_checked,
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("triggered_delayed_pulse_generator test passed");
    end else begin
      $display("triggered_delayed_pulse_generator test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tdpg_pkg.sv
design/tdpg_if.sv
design/triggered_delayed_pulse_generator.sv
tb/tb.sv
